/* rtl/lotoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotoa_pkg
// shared types, widths and tables for the time-on-air calculator
// ----------------------------------------------------------------------------
package lotoa_pkg;

    localparam int LEN_W      = 8;
    localparam int MS_W       = 26;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 2;
    localparam int PRE_W      = 16;
    localparam int SF_W       = 4;
    localparam int CR4_W      = 4;
    localparam int DEN_W      = 6;
    localparam int NUM_W      = 12;
    localparam int CQ_W       = 8;
    localparam int CREM_W     = 6;
    localparam int Q_W        = 19;
    localparam int SH_W       = Q_W + 12;
    localparam int N_W        = 40;
    localparam int BW_W       = 19;
    localparam int D_W        = 20;
    localparam int DQ_W       = MS_W;
    localparam int DREM_W     = 20;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam logic [MS_W-1:0] AIRTIME_MAX = MS_W'(40000000);

    localparam logic [IDX_W-1:0] REG_MODEM_ONE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MODEM_TWO   = 2'd1;
    localparam logic [IDX_W-1:0] REG_MODEM_THREE = 2'd2;
    localparam logic [IDX_W-1:0] REG_PREAMBLE    = 2'd3;

    typedef struct packed {
        logic [7:0]       modem_one;
        logic [7:0]       modem_two;
        logic [7:0]       modem_three;
        logic [PRE_W-1:0] preamble;
    } cfg_t;

    typedef struct packed {
        logic             zero;
        logic [NUM_W-1:0] cnum;
        logic [DEN_W-1:0] den;
        logic [CR4_W-1:0] cr4;
        logic [SF_W-1:0]  sf;
        logic [BW_W-1:0]  bw;
        logic [PRE_W-1:0] pre;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic push;
        logic pop;
    } fifo_stat_t;

    function automatic logic [BW_W-1:0] bw_hz(input logic [3:0] code);
        logic [BW_W-1:0] hz;
        unique case (code)
            4'd0:    hz = BW_W'(7800);
            4'd1:    hz = BW_W'(10400);
            4'd2:    hz = BW_W'(15600);
            4'd3:    hz = BW_W'(20800);
            4'd4:    hz = BW_W'(31250);
            4'd5:    hz = BW_W'(41700);
            4'd6:    hz = BW_W'(62500);
            4'd7:    hz = BW_W'(125000);
            4'd8:    hz = BW_W'(250000);
            4'd9:    hz = BW_W'(500000);
            default: hz = BW_W'(125000);
        endcase
        return hz;
    endfunction

endpackage

/* rtl/lotoa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotoa_front
// accepts payload lengths and decodes the modem setup into a job record
// ----------------------------------------------------------------------------
module lotoa_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lotoa_pkg::cfg_t             cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lotoa_pkg::LEN_W-1:0] s_payload_length,
    output logic                        push_valid,
    input  logic                        push_ready,
    output lotoa_pkg::job_t             push_job
);
    import lotoa_pkg::*;

    logic             vld_reg, vld_next;
    job_t             job_reg, job_next;
    logic [SF_W-1:0]  sf_raw, sf;
    logic [2:0]       cr_raw, cr;
    logic [12:0]      pos, neg, num;
    logic [DEN_W-1:0] den;
    logic             take;

    always_comb begin
        sf_raw = cfg.modem_two[7:4];
        if (sf_raw < 4'd6) begin
            sf = 4'd6;
        end else if (sf_raw > 4'd12) begin
            sf = 4'd12;
        end else begin
            sf = sf_raw;
        end
        cr_raw = cfg.modem_one[3:1];
        if (cr_raw == 3'd0) begin
            cr = 3'd1;
        end else if (cr_raw > 3'd4) begin
            cr = 3'd4;
        end else begin
            cr = cr_raw;
        end
        den = {sf - (cfg.modem_three[3] ? 4'd2 : 4'd0), 2'b00};
        pos = 13'({s_payload_length, 3'b000}) + 13'd28
            + (cfg.modem_two[2] ? 13'd16 : 13'd0);
        neg = 13'({sf, 2'b00}) + (cfg.modem_one[0] ? 13'd20 : 13'd0);
        num = pos - neg;

        job_next.zero = (s_payload_length == '0);
        job_next.cnum = (pos <= neg) ? '0 : NUM_W'(num + 13'(den) - 13'd1);
        job_next.den  = den;
        job_next.cr4  = CR4_W'(cr) + CR4_W'(4);
        job_next.sf   = sf;
        job_next.bw   = bw_hz(cfg.modem_one[7:4]);
        job_next.pre  = cfg.preamble;
    end

    assign s_ready    = !vld_reg || push_ready;
    assign take       = s_valid && s_ready;
    assign push_valid = vld_reg;
    assign push_job   = job_reg;

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (push_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            job_reg <= job_next;
        end
    end

endmodule

/* rtl/lotoa_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotoa_fifo
// short job queue between the decode front and the arithmetic back
// ----------------------------------------------------------------------------
module lotoa_fifo #(
    parameter int DEPTH = lotoa_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  lotoa_pkg::job_t      push_job,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output lotoa_pkg::job_t      pop_job,
    output lotoa_pkg::fifo_stat_t stat
);
    import lotoa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    assign stat.full  = !push_ready;
    assign stat.empty = !pop_valid;
    assign stat.push  = push_valid && push_ready;
    assign stat.pop   = pop_ready && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/lotoa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotoa_back
// pipelined symbol ceiling, quarter-symbol scaling and bandwidth division
// ----------------------------------------------------------------------------
module lotoa_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  lotoa_pkg::job_t            pop_job,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lotoa_pkg::MS_W-1:0] m_airtime_ms
);
    import lotoa_pkg::*;

    localparam int CS = CQ_W;
    localparam int DS = DQ_W;

    logic adv;

    // ceiling division stages
    logic              c_vld_reg [CS];
    job_t              c_job_reg [CS];
    logic [CREM_W-1:0] c_rem_reg [CS];
    logic [CQ_W-1:0]   c_q_reg   [CS];

    // scaling stages
    logic              q_vld_reg;
    logic              q_zero_reg;
    logic [SF_W-1:0]   q_sf_reg;
    logic [BW_W-1:0]   q_bw_reg;
    logic [Q_W-1:0]    q_qtr_reg, q_qtr_next;
    logic              n_vld_reg;
    logic              n_zero_reg;
    logic [D_W-1:0]    n_d_reg;
    logic [N_W-1:0]    n_num_reg, n_num_next;
    logic [SH_W-1:0]   shifted;

    // bandwidth division stages
    logic              d_vld_reg  [DS];
    logic              d_zero_reg [DS];
    logic [D_W-1:0]    d_d_reg    [DS];
    logic [N_W-1:0]    d_num_reg  [DS];
    logic [DREM_W-1:0] d_rem_reg  [DS];
    logic [DQ_W-1:0]   d_q_reg    [DS];

    logic              out_vld_reg;
    logic [MS_W-1:0]   out_ms_reg, out_ms_next;

    assign adv          = !out_vld_reg || m_ready;
    assign pop_ready    = adv;
    assign m_valid      = out_vld_reg;
    assign m_airtime_ms = out_ms_reg;

    for (genvar i = 0; i < CS; i++) begin : g_ceil
        logic              in_vld;
        job_t              in_job;
        logic [CREM_W-1:0] in_rem;
        logic [CQ_W-1:0]   in_q;
        logic [CREM_W:0]   trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign in_vld = pop_valid;
            assign in_job = pop_job;
            assign in_rem = CREM_W'(pop_job.cnum[NUM_W-1:CQ_W]);
            assign in_q   = '0;
        end else begin : g_next
            assign in_vld = c_vld_reg[i-1];
            assign in_job = c_job_reg[i-1];
            assign in_rem = c_rem_reg[i-1];
            assign in_q   = c_q_reg[i-1];
        end

        assign trial = {in_rem, in_job.cnum[CQ_W-1-i]};
        assign ge    = (trial >= (CREM_W+1)'(in_job.den));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                c_vld_reg[i] <= 1'b0;
            end else if (adv) begin
                c_vld_reg[i] <= in_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                c_job_reg[i] <= in_job;
                c_rem_reg[i] <= ge ? CREM_W'(trial - (CREM_W+1)'(in_job.den))
                                   : CREM_W'(trial);
                c_q_reg[i]   <= {in_q[CQ_W-2:0], ge};
            end
        end
    end

    always_comb begin
        q_qtr_next = Q_W'({c_job_reg[CS-1].pre, 2'b00}) + Q_W'(49)
                   + Q_W'({Q_W'(c_q_reg[CS-1]) * Q_W'(c_job_reg[CS-1].cr4), 2'b00});
        shifted    = SH_W'(q_qtr_reg) << q_sf_reg;
        n_num_next = N_W'(shifted) * N_W'(500) + N_W'(q_bw_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
        end else if (adv) begin
            q_vld_reg <= c_vld_reg[CS-1];
            n_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_zero_reg <= c_job_reg[CS-1].zero;
            q_sf_reg   <= c_job_reg[CS-1].sf;
            q_bw_reg   <= c_job_reg[CS-1].bw;
            q_qtr_reg  <= q_qtr_next;
            n_zero_reg <= q_zero_reg;
            n_d_reg    <= {q_bw_reg, 1'b0};
            n_num_reg  <= n_num_next;
        end
    end

    for (genvar i = 0; i < DS; i++) begin : g_div
        logic              in_vld;
        logic              in_zero;
        logic [D_W-1:0]    in_d;
        logic [N_W-1:0]    in_num;
        logic [DREM_W-1:0] in_rem;
        logic [DQ_W-1:0]   in_q;
        logic [DREM_W:0]   trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign in_vld  = n_vld_reg;
            assign in_zero = n_zero_reg;
            assign in_d    = n_d_reg;
            assign in_num  = n_num_reg;
            assign in_rem  = DREM_W'(n_num_reg[N_W-1:DQ_W]);
            assign in_q    = '0;
        end else begin : g_next
            assign in_vld  = d_vld_reg[i-1];
            assign in_zero = d_zero_reg[i-1];
            assign in_d    = d_d_reg[i-1];
            assign in_num  = d_num_reg[i-1];
            assign in_rem  = d_rem_reg[i-1];
            assign in_q    = d_q_reg[i-1];
        end

        assign trial = {in_rem, in_num[DQ_W-1-i]};
        assign ge    = (trial >= (DREM_W+1)'(in_d));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_vld_reg[i] <= 1'b0;
            end else if (adv) begin
                d_vld_reg[i] <= in_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                d_zero_reg[i] <= in_zero;
                d_d_reg[i]    <= in_d;
                d_num_reg[i]  <= in_num;
                d_rem_reg[i]  <= ge ? DREM_W'(trial - (DREM_W+1)'(in_d))
                                    : DREM_W'(trial);
                d_q_reg[i]    <= {in_q[DQ_W-2:0], ge};
            end
        end
    end

    always_comb begin
        if (d_zero_reg[DS-1]) begin
            out_ms_next = '0;
        end else if (d_q_reg[DS-1] > AIRTIME_MAX) begin
            out_ms_next = AIRTIME_MAX;
        end else begin
            out_ms_next = d_q_reg[DS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= d_vld_reg[DS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_ms_reg <= out_ms_next;
        end
    end

endmodule

/* rtl/lora_time_on_air_calc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lora_time_on_air_calc_core
// LoRa packet time on air in milliseconds from a payload length
// ----------------------------------------------------------------------------
// One payload length is taken per clock while s_ready is high, and one
// rounded, saturating airtime comes out per length, in order. After the
// decode register a length passes through the bit-serial symbol ceiling,
// the quarter-symbol scaling registers, the pipelined bandwidth divider and
// the output register. Stalls at the output hold the whole arithmetic
// pipeline; the job queue absorbs up to FIFO_DEPTH lengths.
// ----------------------------------------------------------------------------
module lora_time_on_air_calc_core #(
    parameter int FIFO_DEPTH = lotoa_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lotoa_pkg::IDX_W-1:0] cfg_addr,
    input  logic [lotoa_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lotoa_pkg::LEN_W-1:0] s_payload_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lotoa_pkg::MS_W-1:0]  m_airtime_ms
);
    import lotoa_pkg::*;

    cfg_t       cfg_reg;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    job_t       push_job, pop_job;
    fifo_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modem_one   <= 8'd114;
            cfg_reg.modem_two   <= 8'd116;
            cfg_reg.modem_three <= 8'd4;
            cfg_reg.preamble    <= PRE_W'(12);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MODEM_ONE:   cfg_reg.modem_one   <= cfg_wdata[7:0];
                REG_MODEM_TWO:   cfg_reg.modem_two   <= cfg_wdata[7:0];
                REG_MODEM_THREE: cfg_reg.modem_three <= cfg_wdata[7:0];
                REG_PREAMBLE:    cfg_reg.preamble    <= cfg_wdata[PRE_W-1:0];
                default: ;
            endcase
        end
    end

    lotoa_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload_length (s_payload_length),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_job         (push_job)
    );

    lotoa_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .stat       (stat)
    );

    lotoa_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_airtime_ms (m_airtime_ms)
    );

    a_ms_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_airtime_ms <= AIRTIME_MAX))
        else $error("airtime above saturation limit");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !stat.push)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.empty |-> !stat.pop)
        else $error("job queue read while empty");

endmodule

/* sim/lotoa_airtime_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lotoa_airtime_checker
// predicts and checks the airtime results of the time-on-air core
// ----------------------------------------------------------------------------
// Mirrors the configuration writes and works out the rounded, saturating
// airtime for every length accepted on the input channel. Each result taken
// from the output channel is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module lotoa_airtime_checker
    import lotoa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [LEN_W-1:0] s_payload_length,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [MS_W-1:0]  m_airtime_ms,
    output int               mismatches,
    output int               outstanding
);

    localparam int unsigned BW_HZ[16] = '{7800, 10400, 15600, 20800, 31250, 41700,
        62500, 125000, 250000, 500000, 125000, 125000, 125000, 125000, 125000, 125000};

    logic [7:0]       cfg_one;
    logic [7:0]       cfg_two;
    logic [7:0]       cfg_three;
    logic [PRE_W-1:0] cfg_pre;
    logic [MS_W-1:0]  airtime_q[$];
    int               fail_cnt = 0;

    function automatic logic [MS_W-1:0] airtime_of(input logic [LEN_W-1:0] len);
        int sf, cr, num, den, ceil_syms;
        longint unsigned bw, quarters, scaled, ms;
        if (len == 0) begin
            return '0;
        end
        sf = int'(cfg_two[7:4]);
        if (sf < 6) sf = 6;
        if (sf > 12) sf = 12;
        cr = int'(cfg_one[3:1]);
        if (cr < 1) cr = 1;
        if (cr > 4) cr = 4;
        bw  = BW_HZ[cfg_one[7:4]];
        num = 8 * int'(len) - 4 * sf + 28 + 16 * int'(cfg_two[2]) - 20 * int'(cfg_one[0]);
        den = 4 * (sf - 2 * int'(cfg_three[3]));
        ceil_syms = (num <= 0) ? 0 : (num + den - 1) / den;
        quarters = 4 * longint'(cfg_pre) + 17 + 4 * (8 + longint'(ceil_syms) * (cr + 4));
        scaled   = quarters * (64'd1 << sf) * 250;
        ms       = (2 * scaled + bw) / (2 * bw);
        if (ms > 40000000) ms = 40000000;
        return MS_W'(ms);
    endfunction

    always @(posedge aclk) begin
        logic [MS_W-1:0] exp_ms;
        if (!aresetn) begin
            cfg_one   = 8'd114;
            cfg_two   = 8'd116;
            cfg_three = 8'd4;
            cfg_pre   = 16'd12;
            airtime_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (airtime_q.size() == 0) begin
                    $error("unexpected result transaction: airtime_ms actual %0d", m_airtime_ms);
                    fail_cnt++;
                end else begin
                    exp_ms = airtime_q.pop_front();
                    if (m_airtime_ms !== exp_ms) begin
                        $error("airtime_ms mismatch: expected %0d actual %0d",
                               exp_ms, m_airtime_ms);
                        fail_cnt++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                airtime_q.push_back(airtime_of(s_payload_length));
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MODEM_ONE:   cfg_one   = cfg_wdata[7:0];
                    REG_MODEM_TWO:   cfg_two   = cfg_wdata[7:0];
                    REG_MODEM_THREE: cfg_three = cfg_wdata[7:0];
                    REG_PREAMBLE:    cfg_pre   = cfg_wdata[PRE_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatches  <= fail_cnt;
        outstanding <= airtime_q.size();
    end

endmodule

/* sim/tb_lora_time_on_air_calc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lora_time_on_air_calc_core
// testbench for the LoRa time-on-air core
// ----------------------------------------------------------------------------
// Walks the core through many modem settings: a short directed set of corner
// settings and lengths, then random settings with random lengths, random
// stalls on both channels, one long output hold-off and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb_lora_time_on_air_calc_core;
    import lotoa_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    logic [LEN_W-1:0] s_payload_length;
    logic             m_valid;
    logic             m_ready;
    logic [MS_W-1:0]  m_airtime_ms;
    int               mismatches;
    int               outstanding;
    bit               stalls_on;
    bit               hold_req;

    lora_time_on_air_calc_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload_length(s_payload_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_airtime_ms(m_airtime_ms)
    );

    lotoa_airtime_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload_length(s_payload_length),
        .m_valid(m_valid), .m_ready(m_ready), .m_airtime_ms(m_airtime_ms),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin
        int burst;
        int hold;
        bit hold_done;
        burst     = 0;
        hold      = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_length(input logic [LEN_W-1:0] len);
        s_valid          <= 1'b1;
        s_payload_length <= len;
        do @(posedge aclk); while (!s_ready);
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_cfg(input logic [7:0] one, input logic [7:0] two,
                             input logic [7:0] three, input logic [15:0] pre);
        drain();
        cfg_we <= 1'b1; cfg_addr <= REG_MODEM_ONE;   cfg_wdata <= {8'd0, one};
        @(posedge aclk);
        cfg_addr <= REG_MODEM_TWO;   cfg_wdata <= {8'd0, two};
        @(posedge aclk);
        cfg_addr <= REG_MODEM_THREE; cfg_wdata <= {8'd0, three};
        @(posedge aclk);
        cfg_addr <= REG_PREAMBLE;    cfg_wdata <= pre;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] rand_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 8'd255;
            2:       return 8'd1;
            3:       return LEN_W'($urandom_range(1, 12));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_preamble();
        case ($urandom_range(0, 7))
            0:       return 16'hffff;
            1:       return 16'd6;
            2:       return 16'($urandom_range(0, 5));
            3:       return 16'($urandom);
            default: return 16'($urandom_range(6, 64));
        endcase
    endfunction

    initial begin
        logic [7:0]  d_one[7]   = '{8'h72, 8'h00, 8'hf1, 8'h0e, 8'ha4, 8'h93, 8'h7f};
        logic [7:0]  d_two[7]   = '{8'h74, 8'h00, 8'hc0, 8'hf4, 8'h64, 8'h50, 8'hff};
        logic [7:0]  d_three[7] = '{8'h04, 8'h00, 8'h08, 8'hf7, 8'h08, 8'hff, 8'h00};
        logic [15:0] d_pre[7]   = '{16'd12, 16'd0, 16'hffff, 16'd6, 16'd3, 16'd8, 16'd65534};
        logic [7:0]  d_len[3]   = '{8'd1, 8'd255, 8'd0};
        int phase;
        int n;

        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_payload_length = '0;
        stalls_on        = 1'b1;
        hold_req         = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first, then corner settings
        send_length(8'd128);
        send_length(8'd2);
        for (int i = 0; i < 7; i++) begin
            write_cfg(d_one[i], d_two[i], d_three[i], d_pre[i]);
            for (int k = 0; k < 3; k++) send_length(d_len[k]);
        end

        for (phase = 0; phase < 25; phase++) begin
            if (phase == 21) stalls_on = 1'b0;
            if (phase % 4 == 0) begin
                write_cfg({4'($urandom_range(0, 1) * 15), 3'($urandom_range(0, 1) * 7),
                           1'($urandom)},
                          {4'($urandom_range(0, 1) * 15), 4'($urandom)},
                          8'($urandom), $urandom_range(0, 1) ? 16'hffff : 16'd6);
            end else begin
                write_cfg(8'($urandom), 8'($urandom), 8'($urandom), rand_preamble());
            end
            n = 50;
            if (phase == 10) begin
                hold_req = 1'b1;
                n = 60;
            end
            for (int k = 0; k < n; k++) send_length(rand_length());
        end

        drain();
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lotoa_pkg.sv
rtl/lotoa_front.sv
rtl/lotoa_fifo.sv
rtl/lotoa_back.sv
rtl/lora_time_on_air_calc_core.sv
sim/lotoa_airtime_checker.sv
sim/tb_lora_time_on_air_calc_core.sv
